// File: design/lprf_pkg.sv
`default_nettype none
package lprf_pkg;

    // point and angle formats
    localparam int COORD_BITS    = 20;
    localparam int STRENGTH_BITS = 16;
    localparam int AZ_BITS       = 16;
    localparam int ANGLE_STAGES  = 16;
    localparam int TAB_LEN       = 24;
    localparam int SH_W          = 5;
    localparam int GUARD_SHIFT   = 24;
    localparam int ANG_FRAC      = 16;
    localparam int ATAN_W        = 30;
    localparam int ACC_W         = 34;
    localparam int Q_W           = ACC_W - ANG_FRAC;
    localparam int ROT_W         = COORD_BITS + GUARD_SHIFT + 4;
    localparam int SQ_W          = 2 * COORD_BITS;
    localparam int R2_W          = SQ_W + 1;
    localparam int HALF_TURN     = 18000;
    localparam int FULL_TURN     = 36000;

    // stream and register port
    localparam int POINT_BITS = 3 * COORD_BITS + STRENGTH_BITS;
    localparam int TDATA_W    = ((POINT_BITS + 7) / 8) * 8;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_MIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_MAX  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MAX   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AZIMUTH_MIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AZIMUTH_MAX = 3'd5;

    typedef struct packed {
        logic [STRENGTH_BITS-1:0]     strength;
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } point_t;

    // one item as it moves down the rotation chain
    typedef struct packed {
        logic                    keep;
        logic                    orig;
        logic signed [ACC_W-1:0] acc;
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        point_t                  pt;
    } cordic_t;

    // atan(2^-i) in units of 2^-16 of 0.01 degree
    function automatic logic [ATAN_W-1:0] atan_unit(input logic [SH_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 30'd294912000;
            5'd1:  v = 30'd174096719;
            5'd2:  v = 30'd91987925;
            5'd3:  v = 30'd46694507;
            5'd4:  v = 30'd23437865;
            5'd5:  v = 30'd11730358;
            5'd6:  v = 30'd5866610;
            5'd7:  v = 30'd2933484;
            5'd8:  v = 30'd1466764;
            5'd9:  v = 30'd733385;
            5'd10: v = 30'd366693;
            5'd11: v = 30'd183346;
            5'd12: v = 30'd91673;
            5'd13: v = 30'd45837;
            5'd14: v = 30'd22918;
            5'd15: v = 30'd11459;
            5'd16: v = 30'd5730;
            5'd17: v = 30'd2865;
            5'd18: v = 30'd1432;
            5'd19: v = 30'd716;
            5'd20: v = 30'd358;
            5'd21: v = 30'd179;
            5'd22: v = 30'd90;
            5'd23: v = 30'd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: design/lidar_point_region_filter_unit.sv
`default_nettype none
// point crop filter: height, squared horizontal range and cordic azimuth windows
// path: front stages a and b, the rotation cells, back stages, then the output register
// throughput: one point per cycle; the pipeline advances as one chain of registers
// and stops only while both the output register and its skid register are full
// reset: synchronous active-low aresetn clears all valid bits and sets every
// window register to zero; no clearing pass, s_tready is high the cycle after
module lidar_point_region_filter_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input point stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: pos_x, pos_y, pos_z, strength, zero pad
    input  wire logic [lprf_pkg::TDATA_W-1:0]   s_tdata,
    // kept point stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // fields from bit 0: kept_x, kept_y, kept_z, kept_strength, zero pad
    output logic [lprf_pkg::TDATA_W-1:0]        m_tdata,
    // register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lprf_pkg::APB_AW-1:0]    paddr,
    input  wire logic [lprf_pkg::APB_DW-1:0]    pwdata,
    output logic [lprf_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import lprf_pkg::*;

    // window registers, kept as written; range bounds also kept squared
    logic [COORD_BITS-1:0] height_min_reg, height_max_reg;
    logic [COORD_BITS-1:0] range_min_reg, range_max_reg;
    logic [SQ_W-1:0]       range_min_sq_reg, range_max_sq_reg;
    logic [AZ_BITS-1:0]    azimuth_min_reg, azimuth_max_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [COORD_BITS-1:0] wr_coord;
    logic [SQ_W-1:0]       wr_sq;

    // pipeline
    logic    en;
    point_t  in_pt;
    logic    chain_vld [0:ANGLE_STAGES];
    cordic_t chain_item [0:ANGLE_STAGES];
    logic    emit;
    point_t  emit_pt;

    // output register and skid register
    logic   out_vld_reg, out_vld_next;
    point_t out_pt_reg, out_pt_next;
    logic   skid_vld_reg, skid_vld_next;
    point_t skid_pt_reg, skid_pt_next;

    // ---------------------------------------------------------------
    // register port: write at the access phase, reads always ready
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign reg_idx  = paddr[APB_AW-1:2];
    assign wr_coord = pwdata[COORD_BITS-1:0];
    // square of the written range bound, one multiplier into its register
    assign wr_sq    = SQ_W'(wr_coord) * SQ_W'(wr_coord);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_min_reg   <= '0;
            height_max_reg   <= '0;
            range_min_reg    <= '0;
            range_max_reg    <= '0;
            range_min_sq_reg <= '0;
            range_max_sq_reg <= '0;
            azimuth_min_reg  <= '0;
            azimuth_max_reg  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEIGHT_MIN:  height_min_reg <= wr_coord;
                REG_HEIGHT_MAX:  height_max_reg <= wr_coord;
                REG_RANGE_MIN: begin
                    range_min_reg    <= wr_coord;
                    range_min_sq_reg <= wr_sq;
                end
                REG_RANGE_MAX: begin
                    range_max_reg    <= wr_coord;
                    range_max_sq_reg <= wr_sq;
                end
                REG_AZIMUTH_MIN: azimuth_min_reg <= pwdata[AZ_BITS-1:0];
                REG_AZIMUTH_MAX: azimuth_max_reg <= pwdata[AZ_BITS-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEIGHT_MIN:  prdata = APB_DW'(height_min_reg);
            REG_HEIGHT_MAX:  prdata = APB_DW'(height_max_reg);
            REG_RANGE_MIN:   prdata = APB_DW'(range_min_reg);
            REG_RANGE_MAX:   prdata = APB_DW'(range_max_reg);
            REG_AZIMUTH_MIN: prdata = APB_DW'(azimuth_min_reg);
            REG_AZIMUTH_MAX: prdata = APB_DW'(azimuth_max_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline: front stages, rotation cells, azimuth finish
    // ---------------------------------------------------------------
    // the whole chain moves while the skid register is free, so an input
    // transfer is still taken while one kept point waits at the output
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    assign in_pt.x        = s_tdata[COORD_BITS-1:0];
    assign in_pt.y        = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_pt.z        = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_pt.strength = s_tdata[POINT_BITS-1:3*COORD_BITS];

    // squares and height test, then range test; emits the pre-rotated vector
    lprf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_vld       (s_tvalid),
        .in_pt        (in_pt),
        .height_min   (height_min_reg),
        .height_max   (height_max_reg),
        .range_min_sq (range_min_sq_reg),
        .range_max_sq (range_max_sq_reg),
        .out_vld      (chain_vld[0]),
        .out_item     (chain_item[0])
    );

    // one vectoring rotation per cell, cell g shifts by g
    for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cell
        lprf_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .shift_amt (SH_W'(g)),
            .atan_step (atan_unit(SH_W'(g))),
            .in_vld    (chain_vld[g]),
            .in_item   (chain_item[g]),
            .out_vld   (chain_vld[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // rounding, wrap into one turn, azimuth window
    lprf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_vld      (chain_vld[ANGLE_STAGES]),
        .in_item     (chain_item[ANGLE_STAGES]),
        .azimuth_min (azimuth_min_reg),
        .azimuth_max (azimuth_max_reg),
        .emit        (emit),
        .emit_pt     (emit_pt)
    );

    // ---------------------------------------------------------------
    // output register with skid: a kept point that meets a stalled
    // output parks in the skid register and drains first
    // ---------------------------------------------------------------
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_pt_next   = out_pt_reg;
        skid_vld_next = skid_vld_reg;
        skid_pt_next  = skid_pt_reg;
        if (skid_vld_reg) begin
            if (!out_vld_reg || m_tready) begin
                out_vld_next  = 1'b1;
                out_pt_next   = skid_pt_reg;
                skid_vld_next = 1'b0;
            end
        end else if (en && emit) begin
            if (out_vld_reg && !m_tready) begin
                skid_vld_next = 1'b1;
                skid_pt_next  = emit_pt;
            end else begin
                out_vld_next = 1'b1;
                out_pt_next  = emit_pt;
            end
        end else if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_pt_reg  <= out_pt_next;
        skid_pt_reg <= skid_pt_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = TDATA_W'(out_pt_reg);

endmodule
`default_nettype wire

// File: design/lprf_front.sv
`default_nettype none
module lprf_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_vld,
    input  wire lprf_pkg::point_t               in_pt,
    input  wire logic [lprf_pkg::COORD_BITS-1:0] height_min,
    input  wire logic [lprf_pkg::COORD_BITS-1:0] height_max,
    input  wire logic [lprf_pkg::SQ_W-1:0]      range_min_sq,
    input  wire logic [lprf_pkg::SQ_W-1:0]      range_max_sq,
    output logic                                out_vld,
    output lprf_pkg::cordic_t                   out_item
);
    import lprf_pkg::*;

    logic signed [COORD_BITS-1:0] x, y, z;
    logic                         x_neg;
    logic [COORD_BITS-1:0]        ax, ay;
    logic signed [ROT_W-1:0]      xe, ye, px, py;
    logic                         hok;

    // stage a: squares, height window, half-turn pre-rotation
    logic                    a_vld_reg;
    point_t                  a_pt_reg;
    logic [SQ_W-1:0]         a_sqx_reg, a_sqy_reg;
    logic                    a_hok_reg, a_orig_reg;
    logic signed [ROT_W-1:0] a_rx_reg, a_ry_reg;
    logic signed [ACC_W-1:0] a_acc_reg;

    logic [R2_W-1:0] r2;
    logic            rok;
    logic            b_vld_reg;
    cordic_t         b_item_reg;

    assign x     = in_pt.x;
    assign y     = in_pt.y;
    assign z     = in_pt.z;
    assign x_neg = x[COORD_BITS-1];
    assign ax    = x_neg ? COORD_BITS'(-x) : COORD_BITS'(x);
    assign ay    = y[COORD_BITS-1] ? COORD_BITS'(-y) : COORD_BITS'(y);
    assign xe    = ROT_W'(x);
    assign ye    = ROT_W'(y);
    assign px    = x_neg ? -xe : xe;
    assign py    = x_neg ? -ye : ye;
    assign hok   = (z >= $signed(height_min)) && (z <= $signed(height_max));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_pt_reg   <= in_pt;
            a_sqx_reg  <= SQ_W'(ax) * SQ_W'(ax);
            a_sqy_reg  <= SQ_W'(ay) * SQ_W'(ay);
            a_hok_reg  <= hok;
            a_orig_reg <= (x == '0) && (y == '0);
            a_rx_reg   <= px <<< GUARD_SHIFT;
            a_ry_reg   <= py <<< GUARD_SHIFT;
            a_acc_reg  <= x_neg ? ACC_W'(HALF_TURN * (2 ** ANG_FRAC)) : '0;
        end
    end

    // stage b: squared range against squared window
    assign r2  = R2_W'(a_sqx_reg) + R2_W'(a_sqy_reg);
    assign rok = (r2 >= R2_W'(range_min_sq)) && (r2 <= R2_W'(range_max_sq));

    always_ff @(posedge aclk) begin
        if (en) begin
            b_item_reg.keep <= a_hok_reg && rok;
            b_item_reg.orig <= a_orig_reg;
            b_item_reg.acc  <= a_acc_reg;
            b_item_reg.rx   <= a_rx_reg;
            b_item_reg.ry   <= a_ry_reg;
            b_item_reg.pt   <= a_pt_reg;
        end
    end

    assign out_vld  = b_vld_reg;
    assign out_item = b_item_reg;

endmodule
`default_nettype wire

// File: design/lprf_cordic_cell.sv
`default_nettype none
module lprf_cordic_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic [lprf_pkg::SH_W-1:0]   shift_amt,
    input  wire logic [lprf_pkg::ATAN_W-1:0] atan_step,
    input  wire logic                        in_vld,
    input  wire lprf_pkg::cordic_t           in_item,
    output logic                             out_vld,
    output lprf_pkg::cordic_t                out_item
);
    import lprf_pkg::*;

    logic signed [ROT_W-1:0] rx, ry, tx, ty;
    logic signed [ACC_W-1:0] acc, step;
    logic                    up;
    logic                    vld_reg;
    cordic_t                 item_reg;

    assign rx   = in_item.rx;
    assign ry   = in_item.ry;
    assign acc  = in_item.acc;
    assign tx   = rx >>> shift_amt;
    assign ty   = ry >>> shift_amt;
    assign step = ACC_W'(atan_step);
    // rotate toward the x axis: y >= 0 turns clockwise
    assign up   = !ry[ROT_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg.keep <= in_item.keep;
            item_reg.orig <= in_item.orig;
            item_reg.pt   <= in_item.pt;
            item_reg.rx   <= up ? rx + ty : rx - ty;
            item_reg.ry   <= up ? ry - tx : ry + tx;
            item_reg.acc  <= up ? acc + step : acc - step;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule
`default_nettype wire

// File: design/lprf_back.sv
`default_nettype none
module lprf_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_vld,
    input  wire lprf_pkg::cordic_t            in_item,
    input  wire logic [lprf_pkg::AZ_BITS-1:0] azimuth_min,
    input  wire logic [lprf_pkg::AZ_BITS-1:0] azimuth_max,
    output logic                              emit,
    output lprf_pkg::point_t                  emit_pt
);
    import lprf_pkg::*;

    logic signed [ACC_W-1:0] rsum;
    logic signed [Q_W-1:0]   q;
    logic [AZ_BITS-1:0]      az;

    logic               a_vld_reg, a_keep_reg;
    logic [AZ_BITS-1:0] a_az_reg;
    point_t             a_pt_reg;
    logic               emit_reg;
    point_t             pt_reg;

    // round half up, then wrap once into one turn
    assign rsum = in_item.acc + ACC_W'(2 ** (ANG_FRAC - 1));
    assign q    = rsum[ACC_W-1:ANG_FRAC];
    always_comb begin
        if (in_item.orig) begin
            az = '0;
        end else if (q[Q_W-1]) begin
            az = AZ_BITS'(q + Q_W'(FULL_TURN));
        end else begin
            az = AZ_BITS'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            emit_reg  <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
            emit_reg  <= a_vld_reg && a_keep_reg &&
                         (a_az_reg >= azimuth_min) && (a_az_reg <= azimuth_max);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_keep_reg <= in_item.keep;
            a_az_reg   <= az;
            a_pt_reg   <= in_item.pt;
            pt_reg     <= a_pt_reg;
        end
    end

    assign emit    = emit_reg;
    assign emit_pt = pt_reg;

endmodule
`default_nettype wire

// File: design/lprf_checker.sv
`default_nettype none
module lprf_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [lprf_pkg::TDATA_W-1:0] m_tdata
);
    import lprf_pkg::*;

    // input side only backs up while a result is waiting
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result waiting");

    // a stalled output keeps the input held off
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !s_tready) |=> !s_tready)
        else $error("input released while output still stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("pipeline not empty after reset");

endmodule

bind lidar_point_region_filter_unit lprf_checker u_lprf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// File: bench/lidar_point_region_filter_unit_test.sv
`timescale 1ns / 100ps

module lidar_point_region_filter_unit_test;
    import lprf_pkg::*;

    // ranges of the coordinate and window registers
    localparam longint COORD_MAX   = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN   = -(longint'(1) << (COORD_BITS - 1));
    localparam longint COORD_FULL  = (longint'(1) << COORD_BITS) - 1;
    localparam longint RANGE_LIMIT = 741455;
    localparam longint AZ_FULL     = (longint'(1) << AZ_BITS) - 1;
    localparam longint ANG_ONE     = longint'(1) << ANG_FRAC;
    localparam int     PAD_BITS    = TDATA_W - POINT_BITS;
    localparam real    PI          = 3.14159265358979;

    // register indexes that decode to nothing
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // give the drain a margin over the whole pipeline path
    localparam int DRAIN_CYCLES     = 40;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PHASES    = 8;
    localparam int POINTS_PER_PHASE = 143;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // fields from bit 0: pos_x, pos_y, pos_z, strength, zero pad
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // fields from bit 0: kept_x, kept_y, kept_z, kept_strength, zero pad
    logic [TDATA_W-1:0]  m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // points waiting to be driven and kept points still to come out
    point_t point_queue[$];
    point_t kept_queue[$];

    // local copy of the crop windows, updated as each register write completes
    longint win_hmin = 0, win_hmax = 0;
    longint win_rmin = 0, win_rmax = 0;
    longint win_amin = 0, win_amax = 0;

    // atan(2^-i) in 2^-16 of a hundredth of a degree
    longint atan_step_units [0:TAB_LEN-1] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610,   2933484,   1466764,  733385,   366693,   183346,
        91673,     45837,     22918,    11459,    5730,     2865,
        1432,      716,       358,      179,      90,       45};

    int error_count = 0;
    int idle_cycles = 0;
    int idle_odds   = 0;   // one idle burst start in idle_odds cycles, 0 = never
    int send_gap    = 0;
    int stall_left  = 0;

    lidar_point_region_filter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial forever #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // vectoring cordic azimuth, hundredths of a degree wrapped to 0..35999
    function automatic longint azimuth_hundredths(longint px, longint py);
        longint rx, ry, acc, dx, dy;
        int i;
        if (px == 0 && py == 0) return 0;
        rx  = px;
        ry  = py;
        acc = 0;
        // left half plane: turn by a half turn first
        if (px < 0) begin
            rx  = -px;
            ry  = -py;
            acc = longint'(HALF_TURN) * ANG_ONE;
        end
        rx = rx <<< GUARD_SHIFT;
        ry = ry <<< GUARD_SHIFT;
        for (i = 0; i < ANGLE_STAGES; i++) begin
            // arithmetic shifts floor toward minus infinity
            dx = rx >>> i;
            dy = ry >>> i;
            if (ry >= 0) begin
                rx  = rx + dy;
                ry  = ry - dx;
                acc = acc + atan_step_units[i];
            end else begin
                rx  = rx - dy;
                ry  = ry + dx;
                acc = acc - atan_step_units[i];
            end
        end
        // offset by two full turns so the sum is positive, round half up
        acc = acc + 2 * longint'(FULL_TURN) * ANG_ONE + ANG_ONE / 2;
        return (acc >>> ANG_FRAC) % FULL_TURN;
    endfunction

    // keep the point when height, squared range and azimuth are all in window
    function automatic void predict_kept(point_t p);
        longint x, y, z, r2, az;
        x  = p.x;
        y  = p.y;
        z  = p.z;
        r2 = x * x + y * y;
        if (z < win_hmin || z > win_hmax) return;
        if (r2 < win_rmin * win_rmin || r2 > win_rmax * win_rmax) return;
        az = azimuth_hundredths(x, y);
        if (az < win_amin || az > win_amax) return;
        kept_queue = {kept_queue, p};
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic longint pick(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX[COORD_BITS-1:0];
        if (v < COORD_MIN) return COORD_MIN[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    // random sign, magnitude spread over every scale
    function automatic logic signed [COORD_BITS-1:0] spread_coord();
        logic signed [COORD_BITS-1:0] c;
        c = COORD_BITS'($urandom);
        return c >>> $urandom_range(0, COORD_BITS - 1);
    endfunction

    // mostly inside the height window, often right at an edge
    function automatic logic signed [COORD_BITS-1:0] pick_height();
        if (win_hmin > win_hmax || $urandom_range(0, 9) == 0) return spread_coord();
        case ($urandom_range(0, 7))
            0:       return clamp_coord(win_hmin - pick(0, 1));
            1:       return clamp_coord(win_hmax + pick(0, 1));
            default: return clamp_coord(pick(win_hmin, win_hmax));
        endcase
    endfunction

    function automatic point_t make_point();
        point_t p;
        longint rlo, rhi, alo, ahi;
        real    rad, ang;
        p.strength = STRENGTH_BITS'($urandom);
        p.x = spread_coord();
        p.y = spread_coord();
        p.z = pick_height();
        rlo = win_rmin;
        rhi = (win_rmax > RANGE_LIMIT) ? RANGE_LIMIT : win_rmax;
        alo = win_amin;
        ahi = (win_amax > FULL_TURN - 1) ? FULL_TURN - 1 : win_amax;
        case ($urandom_range(0, 9))
            // raw noise over every bit
            0: begin
                p.x = COORD_BITS'($urandom);
                p.y = COORD_BITS'($urandom);
                p.z = COORD_BITS'($urandom);
            end
            // around the origin
            1: begin
                p.x = clamp_coord(pick(-4, 4));
                p.y = clamp_coord(pick(-4, 4));
            end
            2, 3: ;
            // on a ring inside the range and azimuth windows
            default: if (rlo <= rhi && alo <= ahi) begin
                rad = real'(pick(rlo, rhi));
                ang = real'(pick(alo, ahi)) * PI / real'(HALF_TURN);
                p.x = clamp_coord(longint'(rad * $cos(ang)));
                p.y = clamp_coord(longint'(rad * $sin(ang)));
            end
        endcase
        return p;
    endfunction

    task automatic add_point(longint x, longint y, longint z, longint s);
        point_t p;
        p.x        = x[COORD_BITS-1:0];
        p.y        = y[COORD_BITS-1:0];
        p.z        = z[COORD_BITS-1:0];
        p.strength = s[STRENGTH_BITS-1:0];
        point_queue = {point_queue, p};
    endtask

    // register word, now and then with junk above the field
    function automatic logic [APB_DW-1:0] with_junk(longint v, int w);
        logic [APB_DW-1:0] m, word;
        m    = (APB_DW'(1) << w) - 1;
        word = APB_DW'(v) & m;
        if ($urandom_range(0, 3) == 0) word = word | ($urandom & ~m);
        return word;
    endfunction

    // setup cycle, access cycle, done at the edge that sees pready
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] word);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HEIGHT_MIN:  win_hmin = longint'($signed(word[COORD_BITS-1:0]));
            REG_HEIGHT_MAX:  win_hmax = longint'($signed(word[COORD_BITS-1:0]));
            REG_RANGE_MIN:   win_rmin = longint'(word[COORD_BITS-1:0]);
            REG_RANGE_MAX:   win_rmax = longint'(word[COORD_BITS-1:0]);
            REG_AZIMUTH_MIN: win_amin = longint'(word[AZ_BITS-1:0]);
            REG_AZIMUTH_MAX: win_amax = longint'(word[AZ_BITS-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_window(longint h0, longint h1, longint r0, longint r1,
                              longint a0, longint a1);
        reg_write(REG_HEIGHT_MIN,  with_junk(h0, COORD_BITS));
        reg_write(REG_HEIGHT_MAX,  with_junk(h1, COORD_BITS));
        reg_write(REG_RANGE_MIN,   with_junk(r0, COORD_BITS));
        reg_write(REG_RANGE_MAX,   with_junk(r1, COORD_BITS));
        reg_write(REG_AZIMUTH_MIN, with_junk(a0, AZ_BITS));
        reg_write(REG_AZIMUTH_MAX, with_junk(a1, AZ_BITS));
    endtask

    // random crop windows: mostly ordered, some open, inverted or unreachable
    task automatic pick_window();
        longint h0, h1, r0, r1, a0, a1, t;
        h0 = spread_coord();
        h1 = spread_coord();
        if (h0 > h1) begin
            t  = h0;
            h0 = h1;
            h1 = t;
        end
        case ($urandom_range(0, 9))
            0: begin
                h0 = COORD_MIN;
                h1 = COORD_MAX;
            end
            1: begin
                h0 = pick(COORD_MIN + 1, COORD_MAX);
                h1 = pick(COORD_MIN, h0 - 1);
            end
            2: h1 = h0;
            default: ;
        endcase
        r0 = pick(0, RANGE_LIMIT) >> $urandom_range(0, 10);
        r1 = r0 + (pick(0, RANGE_LIMIT) >> $urandom_range(0, 10));
        if (r1 > COORD_FULL) r1 = COORD_FULL;
        case ($urandom_range(0, 11))
            0: begin
                r0 = 0;
                r1 = COORD_FULL;
            end
            1: begin
                r1 = pick(0, RANGE_LIMIT - 1);
                r0 = pick(r1 + 1, RANGE_LIMIT);
            end
            2: begin
                r0 = pick(RANGE_LIMIT + 1, COORD_FULL);
                r1 = COORD_FULL;
            end
            3: begin
                r0 = 0;
                r1 = RANGE_LIMIT;
            end
            default: ;
        endcase
        a0 = pick(0, FULL_TURN);
        a1 = pick(0, FULL_TURN);
        if (a0 > a1) begin
            t  = a0;
            a0 = a1;
            a1 = t;
        end
        case ($urandom_range(0, 11))
            0: begin
                a0 = 0;
                a1 = FULL_TURN;
            end
            1: a1 = AZ_FULL;
            2: begin
                a1 = pick(0, FULL_TURN - 1);
                a0 = pick(a1 + 1, AZ_FULL);
            end
            3: begin
                a0 = pick(FULL_TURN, AZ_FULL);
                a1 = AZ_FULL;
            end
            default: ;
        endcase
        set_window(h0, h1, r0, r1, a0, a1);
    endtask

    // all points sent, all kept points seen, then let the pipeline empty
    task automatic wait_idle();
        do @(negedge aclk);
        while (point_queue.size() != 0 || s_tvalid || kept_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // driver: one point per transfer, random idle bursts between them
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_kept(s_tdata[POINT_BITS-1:0]);
            // hold the point on the bus until its transfer
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else if (point_queue.size() != 0) begin
                    s_tdata  <= {{PAD_BITS{1'b0}}, point_queue.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compare each kept point with the oldest one predicted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        point_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[POINT_BITS-1:0];
            if (kept_queue.size() == 0) begin
                $error("unexpected kept point x=%0d y=%0d z=%0d", got.x, got.y, got.z);
                error_count++;
            end else begin
                want = kept_queue.pop_front();
                if (got.x !== want.x) begin
                    $error("kept_x: expected %0d, actual %0d", want.x, got.x);
                    error_count++;
                end
                if (got.y !== want.y) begin
                    $error("kept_y: expected %0d, actual %0d", want.y, got.y);
                    error_count++;
                end
                if (got.z !== want.z) begin
                    $error("kept_z: expected %0d, actual %0d", want.z, got.z);
                    error_count++;
                end
                if (got.strength !== want.strength) begin
                    $error("kept_strength: expected %0d, actual %0d",
                           want.strength, got.strength);
                    error_count++;
                end
            end
        end
        // backpressure in random bursts
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        // cycles since the last transfer on either stream
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
    end

    // watchdog
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        idle_odds = 4;

        // reset windows are all zero: only the origin at zero height passes
        add_point(0, 0, 0, 16'hFFFF);
        add_point(0, 0, 1, 16'h0001);
        add_point(1, 0, 0, 16'h0002);
        wait_idle();

        // fully open windows, unmapped registers must change nothing
        set_window(COORD_MIN, COORD_MAX, 0, COORD_FULL, 0, AZ_FULL);
        reg_write(REG_UNMAPPED_LO, '1);
        reg_write(REG_UNMAPPED_HI, $urandom);
        add_point(COORD_MAX, 0, COORD_MAX, 16'hFFFF);
        add_point(COORD_MIN, 0, COORD_MIN, 16'h0000);
        add_point(0, COORD_MAX, 1, 16'h5555);
        add_point(0, COORD_MIN, -1, 16'hAAAA);
        add_point(COORD_MIN, COORD_MIN, 0, 1);     // corner beyond the range limit
        add_point(COORD_MAX, COORD_MAX, 0, 2);
        add_point(-1, 0, 0, 3);                    // exactly a half turn
        add_point(-1, -1, 0, 4);
        add_point(1, -1, 0, 5);
        add_point(-1, 1, 0, 6);
        add_point(COORD_MAX, -1, 0, 7);            // just short of a full turn, wraps
        add_point(COORD_MIN, 1, 0, 8);
        wait_idle();

        // tight windows with points on and just past each edge
        set_window(-100, 100, 1000, 2000, 4500, 13500);
        add_point(0, 1000, -100, 16'h0010);
        add_point(0, 1000, 100, 16'h0011);
        add_point(0, 1000, -101, 16'h0012);
        add_point(0, 1000, 101, 16'h0013);
        add_point(0, 999, 0, 16'h0014);
        add_point(0, 2000, 0, 16'h0015);
        add_point(0, 2001, 0, 16'h0016);
        add_point(1000, 1000, 0, 16'h0017);        // on the lower azimuth edge
        add_point(-1000, 1000, 0, 16'h0018);       // on the upper azimuth edge
        add_point(600, 800, 0, 16'h0019);          // range exactly at the minimum
        add_point(1200, 1600, 0, 16'h001A);        // range exactly at the maximum
        wait_idle();

        // random windows and points, no idling in the last phase
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_window();
            if (phase == RANDOM_PHASES - 1 || phase % 3 == 1) idle_odds = 0;
            else if (phase % 3 == 0) idle_odds = 3;
            else idle_odds = 6;
            repeat (POINTS_PER_PHASE) point_queue = {point_queue, make_point()};
            wait_idle();
        end

        if (kept_queue.size() != 0) begin
            $error("%0d kept points never arrived", kept_queue.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/lprf_pkg.sv
design/lprf_front.sv
design/lprf_cordic_cell.sv
design/lprf_back.sv
design/lidar_point_region_filter_unit.sv
design/lprf_checker.sv
bench/lidar_point_region_filter_unit_test.sv
